[hw/rtl/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/b2a_pkg.sv]
package b2a_pkg;

    localparam int VAL_W      = 32;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_W      = DEC_DIGITS * 4;
    localparam int STEPS      = 8;
    localparam int DD_STAGES  = VAL_W / STEPS;
    localparam int POS_W      = $clog2(DEC_DIGITS);

    localparam logic [1:0] MODE_DEC = 2'd0;
    localparam logic [1:0] MODE_TWO = 2'd1;
    localparam logic [1:0] MODE_HEX = 2'd2;

    localparam logic [15:0][7:0] HEX_CHARS = {
        8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
    };

    typedef struct packed {
        logic [DEC_DIGITS-1:0][3:0] bcd;
        logic [VAL_W-1:0]           bin;
        logic [7:0]                 low_byte;
        logic [1:0]                 mode;
    } t_dd_item;

    // one shift-and-add-3 step
    function automatic t_dd_item dd_step(input t_dd_item it);
        t_dd_item r;
        r = it;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            if (r.bcd[k] >= 4'd5) begin
                r.bcd[k] = r.bcd[k] + 4'd3;
            end
        end
        {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
        return r;
    endfunction

endpackage

[hw/rtl/binary_to_ascii_number_formatter_unit.sv]
// the first character strobes after an item passes the conversion stages and loads the emitter
// throughput: one character per cycle, an item holds the output for one character per digit
// it shows; four conversion stages buffer items while one is emitted
// busy rises only when all conversion stages are full behind the character emitter
// reset: synchronous active-low i_rst_n clears the stage valid bits and the emitter
module binary_to_ascii_number_formatter_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [b2a_pkg::VAL_W-1:0] i_value,
    input  logic [1:0]              i_mode,
    output logic                    o_strobe,
    output logic [7:0]              o_char_code,
    output logic                    o_last
);
    import b2a_pkg::*;
    `include "assert_macros.svh"

    t_dd_item                stage_in [DD_STAGES];
    t_dd_item                stage_out[DD_STAGES];
    logic [DD_STAGES-1:0]    stage_vin;
    logic [DD_STAGES-1:0]    stage_vout;
    logic [DD_STAGES-1:0]    stage_en;
    logic                    ser_ready;
    logic                    tail_valid;
    logic                    tail_stall;
    t_dd_item                tail_item;

    always_comb begin
        stage_in[0].bcd      = '0;
        stage_in[0].bin      = i_value;
        stage_in[0].low_byte = i_value[7:0];
        stage_in[0].mode     = i_mode;
        stage_vin[0]         = start;
        for (int i = 1; i < DD_STAGES; i++) begin
            stage_in[i]  = stage_out[i-1];
            stage_vin[i] = stage_vout[i-1];
        end
    end

    always_comb begin
        stage_en[DD_STAGES-1] = !stage_vout[DD_STAGES-1] || ser_ready;
        for (int i = DD_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !stage_vout[i] || stage_en[i+1];
        end
    end

    assign busy = !stage_en[0];

    assign tail_valid = stage_vout[DD_STAGES-1];
    assign tail_item  = stage_out[DD_STAGES-1];
    assign tail_stall = tail_valid && !ser_ready;

    for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
        b2a_dd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (stage_en[g]),
            .i_valid (stage_vin[g]),
            .i_item  (stage_in[g]),
            .o_valid (stage_vout[g]),
            .o_item  (stage_out[g])
        );
    end

    b2a_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (tail_valid),
        .i_item      (tail_item),
        .o_ready     (ser_ready),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // a stalled beat at the pipe end holds its payload
    `ASSERT_CLK(a_tail_hold, tail_stall |=> tail_valid && $stable(tail_item), "stalled beat changed")
    `ASSERT_CLK(a_busy_full, busy |-> (&stage_vout), "busy with an empty stage")
    `ASSERT_NEVER(a_busy_ready, busy && ser_ready, "busy while emitter can take a beat")

endmodule

[hw/rtl/b2a_dd_stage.sv]
module b2a_dd_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  b2a_pkg::t_dd_item i_item,
    output logic              o_valid,
    output b2a_pkg::t_dd_item o_item
);
    import b2a_pkg::*;

    t_dd_item n_item;
    t_dd_item r_item;
    logic     r_valid;

    always_comb begin
        n_item = i_item;
        for (int s = 0; s < STEPS; s++) begin
            n_item = dd_step(n_item);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hw/rtl/b2a_serializer.sv]
module b2a_serializer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  b2a_pkg::t_dd_item i_item,
    output logic              o_ready,
    output logic              o_strobe,
    output logic [7:0]        o_char_code,
    output logic              o_last
);
    import b2a_pkg::*;
    `include "assert_macros.svh"

    logic                       r_active;
    logic [POS_W-1:0]           r_pos;
    logic [DEC_DIGITS-1:0][3:0] r_nib;
    logic [POS_W-1:0]           n_pos;
    logic [DEC_DIGITS-1:0][3:0] n_nib;
    logic [POS_W-1:0]           top_pos;
    logic                       load;

    assign o_ready = !r_active || (r_pos == '0);
    assign load    = o_ready && i_valid;

    // highest nonzero digit, at least one digit
    always_comb begin
        top_pos = '0;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            if (i_item.bcd[k] != 4'd0) begin
                top_pos = POS_W'(k);
            end
        end
    end

    always_comb begin
        n_nib = i_item.bcd;
        n_pos = top_pos;
        unique case (i_item.mode)
            MODE_TWO: begin
                n_pos = POS_W'(1);
            end
            MODE_HEX: begin
                n_nib[1] = i_item.low_byte[7:4];
                n_nib[0] = i_item.low_byte[3:0];
                n_pos    = POS_W'(1);
            end
            default: begin
                n_pos = top_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (load) begin
            r_active <= 1'b1;
            r_pos    <= n_pos;
        end else if (r_active) begin
            if (r_pos == '0) begin
                r_active <= 1'b0;
            end else begin
                r_pos <= r_pos - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_nib <= n_nib;
        end
    end

    assign o_strobe    = r_active;
    assign o_char_code = HEX_CHARS[r_nib[r_pos]];
    assign o_last      = r_active && (r_pos == '0);

    `ASSERT_CLK(a_pos_range, r_active |-> (r_pos < POS_W'(DEC_DIGITS)), "digit index out of range")
    `ASSERT_CLK(a_count_down, (r_active && r_pos != '0) |=> (r_active && r_pos == $past(r_pos) - 1'b1), "digit index skipped")
    `ASSERT_CLK(a_no_overrun, (r_active && r_pos != '0) |-> !load, "new beat loaded mid item")

endmodule
